@@ rtl/rbeg_pkg.sv @@
package rbeg_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int POS_W = $clog2(BUFFER_BYTES + 1);

  localparam logic [7:0] EPB_BYTE = 8'h03;
  localparam logic [2:0] TOP_BIT = 3'd7;
  localparam logic [5:0] LAST_ZERO = 6'd31;
  localparam logic [5:0] MAX_FIXED = 6'd32;

  typedef enum logic [2:0] {
    OP_CLEAR       = 3'd0,
    OP_LOAD        = 3'd1,
    OP_FIND        = 3'd2,
    OP_FIXED       = 3'd3,
    OP_UE          = 3'd4,
    OP_SE          = 3'd5,
    OP_RESET_COUNT = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_LONG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_FETCH,
    S_PEEK,
    S_FIND,
    S_FIND_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        bits_consumed;
    logic [12:0]        byte_offset;
    logic signed [32:0] value;
  } result_t;

endpackage

@@ rtl/rbeg_store.sv @@
module rbeg_store (
  input  logic               clk,
  input  rbeg_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);
  import rbeg_pkg::*;

  logic [7:0] mem [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

@@ rtl/rbeg_seq.sv @@
module rbeg_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rbeg_pkg::op_t     cmd_op,
  input  logic [7:0]        data_byte,
  input  logic [5:0]        bit_count,
  output logic              ready,
  output rbeg_pkg::mem_req_t mem_req,
  input  logic [7:0]        rd_data,
  output logic              done,
  output rbeg_pkg::result_t result,
  input  logic              ack
);
  import rbeg_pkg::*;

  state_t           state, state_next;
  op_t              op_r, op_r_next;
  status_t          status_r, status_r_next;
  logic [31:0]      acc, acc_next;
  logic [5:0]       n, n_next;
  logic [5:0]       cnt, cnt_next;
  logic             zero_phase, zero_phase_next;
  logic             fin_pend, fin_pend_next;
  logic [7:0]       cur_byte, cur_byte_next;
  logic             cur_valid, cur_valid_next;
  logic             prev1, prev1_next;
  logic             prev2, prev2_next;
  logic [POS_W-1:0] fill_count, fill_count_next;
  logic [POS_W-1:0] read_pos, read_pos_next;
  logic [2:0]       bit_pos, bit_pos_next;
  logic [1:0]       zero_run, zero_run_next;
  logic [15:0]      bit_counter, bit_counter_next;

  logic [32:0]      tag;
  logic [32:0]      half;
  logic [32:0]      ue_val;
  logic [32:0]      se_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_count  <= '0;
      read_pos    <= '0;
      bit_pos     <= TOP_BIT;
      zero_run    <= 2'd0;
      bit_counter <= 16'd0;
    end else begin
      state       <= state_next;
      fill_count  <= fill_count_next;
      read_pos    <= read_pos_next;
      bit_pos     <= bit_pos_next;
      zero_run    <= zero_run_next;
      bit_counter <= bit_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    status_r   <= status_r_next;
    acc        <= acc_next;
    n          <= n_next;
    cnt        <= cnt_next;
    zero_phase <= zero_phase_next;
    fin_pend   <= fin_pend_next;
    cur_byte   <= cur_byte_next;
    cur_valid  <= cur_valid_next;
    prev1      <= prev1_next;
    prev2      <= prev2_next;
  end

  always_comb begin
    logic             bit_val;
    logic             fin;
    logic [POS_W-1:0] rp;
    logic [1:0]       zr;
    logic             at_end;

    state_next       = state;
    op_r_next        = op_r;
    status_r_next    = status_r;
    acc_next         = acc;
    n_next           = n;
    cnt_next         = cnt;
    zero_phase_next  = zero_phase;
    fin_pend_next    = fin_pend;
    cur_byte_next    = cur_byte;
    cur_valid_next   = cur_valid;
    prev1_next       = prev1;
    prev2_next       = prev2;
    fill_count_next  = fill_count;
    read_pos_next    = read_pos;
    bit_pos_next     = bit_pos;
    zero_run_next    = zero_run;
    bit_counter_next = bit_counter;

    mem_req.we    = 1'b0;
    mem_req.waddr = fill_count[ADDR_W-1:0];
    mem_req.wdata = data_byte;
    mem_req.raddr = read_pos[ADDR_W-1:0];

    bit_val = cur_byte[bit_pos];
    fin     = 1'b0;
    rp      = read_pos + POS_W'(1);
    zr      = 2'd0;
    at_end  = (read_pos >= fill_count);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_r_next      = cmd_op;
          status_r_next  = ST_OK;
          acc_next       = 32'd0;
          cnt_next       = 6'd0;
          fin_pend_next  = 1'b0;
          cur_valid_next = 1'b0;
          prev1_next     = 1'b0;
          prev2_next     = 1'b0;
          unique case (cmd_op)
            OP_CLEAR: begin
              fill_count_next  = '0;
              read_pos_next    = '0;
              bit_pos_next     = TOP_BIT;
              zero_run_next    = 2'd0;
              bit_counter_next = 16'd0;
              state_next       = S_DONE;
            end
            OP_LOAD: begin
              if (fill_count < POS_W'(BUFFER_BYTES)) begin
                mem_req.we      = 1'b1;
                fill_count_next = fill_count + POS_W'(1);
              end
              state_next = S_DONE;
            end
            OP_FIND: begin
              state_next = S_FIND;
            end
            OP_FIXED: begin
              n_next          = (bit_count > MAX_FIXED) ? MAX_FIXED : bit_count;
              zero_phase_next = 1'b0;
              state_next      = S_TAKE;
            end
            OP_UE, OP_SE: begin
              n_next          = 6'd0;
              zero_phase_next = 1'b1;
              state_next      = S_TAKE;
            end
            OP_RESET_COUNT: begin
              bit_counter_next = 16'd0;
              state_next       = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_TAKE: begin
        if (!zero_phase && cnt == n) begin
          state_next = S_DONE;
        end else if (at_end) begin
          status_r_next = ST_FAIL;
          state_next    = S_DONE;
        end else if (!cur_valid) begin
          state_next = S_FETCH;
        end else begin
          bit_counter_next = bit_counter + 16'd1;
          if (zero_phase) begin
            if (bit_val) begin
              zero_phase_next = 1'b0;
              cnt_next        = 6'd0;
            end else begin
              n_next = n + 6'd1;
              if (n == LAST_ZERO) begin
                status_r_next = ST_LONG;
                fin           = 1'b1;
              end
            end
          end else begin
            acc_next = {acc[30:0], bit_val};
            cnt_next = cnt + 6'd1;
          end
          if (bit_pos != 3'd0) begin
            bit_pos_next = bit_pos - 3'd1;
            state_next   = fin ? S_DONE : S_TAKE;
          end else begin
            bit_pos_next   = TOP_BIT;
            read_pos_next  = rp;
            cur_valid_next = 1'b0;
            if (cur_byte == 8'd0) begin
              zr = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
            end else begin
              zr = 2'd0;
            end
            zero_run_next = zr;
            if (zr == 2'd2 && rp < fill_count) begin
              mem_req.raddr = rp[ADDR_W-1:0];
              fin_pend_next = fin;
              state_next    = S_PEEK;
            end else begin
              state_next = fin ? S_DONE : S_TAKE;
            end
          end
        end
      end

      S_FETCH: begin
        cur_byte_next  = rd_data;
        cur_valid_next = 1'b1;
        state_next     = S_TAKE;
      end

      S_PEEK: begin
        if (rd_data != 8'd0) begin
          zero_run_next = 2'd0;
        end
        if (rd_data == EPB_BYTE) begin
          read_pos_next = rp;
        end else begin
          cur_byte_next  = rd_data;
          cur_valid_next = 1'b1;
        end
        state_next = fin_pend ? S_DONE : S_TAKE;
      end

      S_FIND: begin
        if (at_end) begin
          status_r_next = ST_FAIL;
          state_next    = S_DONE;
        end else begin
          state_next = S_FIND_WAIT;
        end
      end

      S_FIND_WAIT: begin
        prev2_next    = prev1;
        prev1_next    = (rd_data == 8'd0);
        read_pos_next = rp;
        if (prev2 && prev1 && rd_data == 8'd1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FIND;
        end
      end

      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign tag    = (33'd1 << n) | {1'b0, acc};
  assign half   = tag >> 1;
  assign ue_val = tag - 33'd1;
  assign se_val = tag[0] ? (33'd0 - half) : half;

  always_comb begin
    result.status        = status_r;
    result.bits_consumed = bit_counter;
    result.byte_offset   = 13'(read_pos);
    result.value         = 33'sd0;
    if (status_r == ST_OK) begin
      unique case (op_r)
        OP_FIXED: result.value = {1'b0, acc};
        OP_UE:    result.value = ue_val;
        OP_SE:    result.value = se_val;
        default:  result.value = 33'sd0;
      endcase
    end
  end

  assign ready = (state == S_IDLE);
  assign done  = (state == S_DONE);

  a_pos_in_fill: assert property (@(posedge clk) disable iff (rst)
    read_pos <= fill_count)
    else $error("read position beyond fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= POS_W'(BUFFER_BYTES))
    else $error("fill count beyond buffer size");

  a_fill_idle_only: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(fill_count))
    else $error("fill count changed during a command");

  a_counter_steps: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_TAKE) |=> $stable(bit_counter))
    else $error("bit counter moved outside a bit step");

  a_peek_zero_run: assert property (@(posedge clk) disable iff (rst)
    state == S_PEEK |-> zero_run == 2'd2)
    else $error("peek without two zero bytes");

endmodule

@@ rtl/rbsp_exp_golomb_bit_reader.sv @@
// H.264 RBSP bit reader. Each input transaction is one command (s_tuser) and
// yields exactly one result transaction. Bytes are loaded into a 4096-byte
// store; fields are read MSB first with emulation prevention bytes dropped.
// Clear, load and counter reset go straight to the done state; start code
// search scans the store one byte at a time; field reads step one bit at a
// time, fetch each byte from the store (the first byte of the command
// included), peek at the next byte after two zero bytes and finish (ue/se
// read 2*len+1 bits). The sequencer has a single bit-serial step unit and
// the byte store a registered read port. s_tready is low while a command
// runs or its result waits in the sequencer; the output register holds one
// result. No clearing pass is run after reset.
module rbsp_exp_golomb_bit_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], bit_count[13:8], zero fill
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // value[32:0], byte_offset[45:33],
                                 // bits_consumed[61:46], status[63:62]
);
  import rbeg_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  result_t    result;
  logic       ready;
  logic       done;
  logic       ack;
  logic       start;

  assign start    = s_tvalid && s_tready;
  assign s_tready = ready;
  assign ack      = done && (!m_tvalid || m_tready);

  rbeg_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rbeg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_op    (op_t'(s_tuser)),
    .data_byte (s_tdata[7:0]),
    .bit_count (s_tdata[13:8]),
    .ready     (ready),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .done      (done),
    .result    (result),
    .ack       (ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      m_tdata <= result;
    end
  end

endmodule

@@ dv/rbsp_exp_golomb_bit_reader_test.sv @@
module rbsp_exp_golomb_bit_reader_test;
  import rbeg_pkg::*;

  localparam logic [2:0] OP_UNKNOWN = 3'd7;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SHOW_LIMIT = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // data_byte[7:0], bit_count[13:8], zero fill
  logic [2:0]  s_tuser = '0;   // op[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // value[32:0], byte_offset[45:33],
                               // bits_consumed[61:46], status[63:62]

  rbsp_exp_golomb_bit_reader u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the reader state
  logic [7:0]  sh_mem [BUFFER_BYTES];
  int unsigned sh_fill = 0;
  int unsigned sh_rd = 0;
  int unsigned sh_bit = TOP_BIT;
  int unsigned sh_zeros = 0;
  int unsigned sh_count = 0;

  result_t     expected_results [$];
  result_t     want;
  result_t     got;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned issued = 0;
  int unsigned src_idle_pct = 21;
  int unsigned sink_idle_pct = 83;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  function automatic void leave_byte();
    logic [7:0] cur;
    logic [7:0] nxt;
    cur = sh_mem[sh_rd];
    sh_rd++;
    if (cur == 8'h00) begin
      if (sh_zeros < 2) sh_zeros++;
    end else begin
      sh_zeros = 0;
    end
    if (sh_zeros >= 2 && sh_rd < sh_fill) begin
      nxt = sh_mem[sh_rd];
      if (nxt != 8'h00) sh_zeros = 0;
      if (nxt == EPB_BYTE) sh_rd++;
    end
  endfunction

  function automatic bit take_bit(output bit b);
    b = 1'b0;
    if (sh_rd >= sh_fill) return 1'b0;
    b = sh_mem[sh_rd][sh_bit];
    if (sh_bit > 0) begin
      sh_bit--;
    end else begin
      sh_bit = TOP_BIT;
      leave_byte();
    end
    sh_count = (sh_count + 1) & 16'hFFFF;
    return 1'b1;
  endfunction

  function automatic status_t read_field(input int unsigned n, output longint unsigned val);
    bit b;
    val = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (!take_bit(b)) begin
        val = 0;
        return ST_FAIL;
      end
      val = (val << 1) | b;
    end
    return ST_OK;
  endfunction

  function automatic status_t read_code_num(output longint unsigned code);
    int unsigned     zeros;
    bit              b;
    longint unsigned rest;
    code = 0;
    zeros = 0;
    b = 1'b0;
    while (!b) begin
      if (!take_bit(b)) return ST_FAIL;
      if (!b) begin
        zeros++;
        if (zeros > LAST_ZERO) return ST_LONG;
      end
    end
    if (read_field(zeros, rest) != ST_OK) return ST_FAIL;
    code = ((64'd1 << zeros) - 1) + rest;
    return ST_OK;
  endfunction

  function automatic status_t scan_start_code();
    int unsigned seen;
    logic [7:0]  w0, w1, w2;
    seen = 0;
    w0 = '0;
    w1 = '0;
    w2 = '0;
    while (sh_rd < sh_fill) begin
      w0 = w1;
      w1 = w2;
      w2 = sh_mem[sh_rd];
      sh_rd++;
      if (seen < 3) seen++;
      if (seen >= 3 && w0 == 8'h00 && w1 == 8'h00 && w2 == 8'h01) return ST_OK;
    end
    return ST_FAIL;
  endfunction

  function automatic result_t decode_command(input logic [2:0] op, input logic [7:0] dbyte,
                                             input logic [5:0] nbits);
    result_t         r;
    longint unsigned code;
    logic [32:0]     v;
    status_t         st;
    int unsigned     n;
    v = '0;
    st = ST_OK;
    code = 0;
    case (op)
      OP_CLEAR: begin
        sh_fill = 0;
        sh_rd = 0;
        sh_bit = TOP_BIT;
        sh_zeros = 0;
        sh_count = 0;
      end
      OP_LOAD: begin
        if (sh_fill < BUFFER_BYTES) begin
          sh_mem[sh_fill] = dbyte;
          sh_fill++;
        end
      end
      OP_FIND: st = scan_start_code();
      OP_FIXED: begin
        n = (nbits > MAX_FIXED) ? MAX_FIXED : nbits;
        st = read_field(n, code);
        v = code[32:0];
      end
      OP_UE: begin
        st = read_code_num(code);
        if (st == ST_OK) v = code[32:0];
      end
      OP_SE: begin
        st = read_code_num(code);
        if (st == ST_OK) v = code[0] ? 33'((code + 1) >> 1) : 33'(0 - (code >> 1));
      end
      OP_RESET_COUNT: sh_count = 0;
      default: ;
    endcase
    r.value = v;
    r.byte_offset = 13'(sh_rd);
    r.bits_consumed = 16'(sh_count);
    r.status = st;
    return r;
  endfunction

  task automatic issue_command(input logic [2:0] op, input logic [7:0] dbyte,
                               input logic [5:0] nbits);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, nbits, dbyte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(decode_command(op, dbyte, nbits));
    issued++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return 8'h00;
    if (pick < 33) return EPB_BYTE;
    if (pick < 40) return 8'h01;
    if (pick < 55) return 8'($urandom_range(1, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [5:0] field_width();
    if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 32));
  endfunction

  function automatic logic [2:0] read_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return OP_FIXED;
    if (pick < 55) return OP_UE;
    if (pick < 80) return OP_SE;
    if (pick < 85) return OP_RESET_COUNT;
    if (pick < 90) return OP_LOAD;
    if (pick < 94) return OP_FIND;
    if (pick < 97) return OP_UNKNOWN;
    return OP_CLEAR;
  endfunction

  task automatic test_start_code();
    issue_command(OP_CLEAR, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h01, 6'd0);
    issue_command(OP_FIND, 8'h00, 6'd0);
    issue_command(OP_FIND, 8'h00, 6'd0);
    issue_command(OP_UNKNOWN, 8'hFF, 6'd63);
  endtask

  task automatic test_fixed_reads();
    issue_command(OP_LOAD, 8'hFF, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_FIXED, 8'h00, 6'd0);
    issue_command(OP_FIXED, 8'h00, 6'd63);
  endtask

  task automatic test_exp_golomb();
    issue_command(OP_LOAD, 8'hA6, 6'd0);
    issue_command(OP_UE, 8'h00, 6'd0);
    issue_command(OP_UE, 8'h00, 6'd0);
    issue_command(OP_SE, 8'h00, 6'd0);
    issue_command(OP_RESET_COUNT, 8'h00, 6'd0);
  endtask

  task automatic test_emulation_prevention();
    issue_command(OP_CLEAR, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_LOAD, EPB_BYTE, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_FIXED, 8'h00, 6'd32);
    // trailing zero pair saw no following byte; this 03 must be read as data
    issue_command(OP_LOAD, EPB_BYTE, 6'd0);
    issue_command(OP_FIXED, 8'h00, 6'd8);
  endtask

  task automatic test_long_code();
    repeat (4) issue_command(OP_LOAD, 8'h00, 6'd0);
    issue_command(OP_UE, 8'h00, 6'd0);
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    issue_command(OP_CLEAR, 8'h00, 6'd0);
    repeat (12) issue_command(OP_LOAD, payload_byte(), field_width());
    repeat (4) issue_command(OP_UE, 8'($urandom_range(0, 255)), field_width());
    wait_drained();
  endtask

  task automatic test_random_streams(input int unsigned quota);
    int unsigned stop_at;
    bit          framed;
    stop_at = issued + quota;
    while (issued < stop_at) begin
      if ($urandom_range(0, 9) < 8) issue_command(OP_CLEAR, payload_byte(), field_width());
      framed = $urandom_range(0, 1);
      if (framed) begin
        repeat ($urandom_range(0, 3)) issue_command(OP_LOAD, payload_byte(), field_width());
        issue_command(OP_LOAD, 8'h00, field_width());
        issue_command(OP_LOAD, 8'h00, field_width());
        issue_command(OP_LOAD, 8'h01, field_width());
      end
      repeat ($urandom_range(2, 20)) issue_command(OP_LOAD, payload_byte(), field_width());
      if (framed || $urandom_range(0, 4) == 0)
        issue_command(OP_FIND, 8'($urandom_range(0, 255)), field_width());
      repeat ($urandom_range(3, 10))
        issue_command(read_op(), payload_byte(), field_width());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      m_tready <= 1'b0;
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= SHOW_LIMIT)
          $display("unexpected result: value=%h off=%0d bits=%0d st=%0d",
                   got.value, got.byte_offset, got.bits_consumed, got.status);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value || got.byte_offset !== want.byte_offset ||
            got.bits_consumed !== want.bits_consumed || got.status !== want.status) begin
          err_count++;
          if (err_count <= SHOW_LIMIT)
            $display({"mismatch: exp value=%h off=%0d bits=%0d st=%0d, ",
                      "got value=%h off=%0d bits=%0d st=%0d"},
                     want.value, want.byte_offset, want.bits_consumed, want.status,
                     got.value, got.byte_offset, got.bits_consumed, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rbsp_exp_golomb_bit_reader_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 21;
    test_start_code();
    test_fixed_reads();
    test_exp_golomb();
    test_emulation_prevention();
    test_long_code();
    test_backpressure();

    src_idle_pct = 83;
    sink_idle_pct <= 21;
    test_random_streams(250);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct <= 0;
    test_random_streams(250);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("rbsp_exp_golomb_bit_reader_test: done, clean");
    end else begin
      $display("rbsp_exp_golomb_bit_reader_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rbeg_pkg.sv
rtl/rbeg_store.sv
rtl/rbeg_seq.sv
rtl/rbsp_exp_golomb_bit_reader.sv
dv/rbsp_exp_golomb_bit_reader_test.sv
